// ===== hw/rtl/mvt_pkg.sv =====
// Shared types and constants of the 4x4 matrix-vector transform unit.
package mvt_pkg;

    localparam int DATA_W    = 32;
    localparam int PROD_W    = 2 * DATA_W;
    localparam int PAIR_W    = PROD_W + 1;
    localparam int SUM_W     = PROD_W + 2;
    localparam int N_DIM     = 4;
    localparam int N_ELEM    = N_DIM * N_DIM;
    localparam int IDX_W     = 4;
    localparam int CMD_DEPTH = 2;
    localparam int RES_DEPTH = 4;
    localparam int RES_CNT_W = $clog2(RES_DEPTH + 1);

    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_XFORM = 1'b1;

    localparam logic signed [DATA_W-1:0] SAT_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [DATA_W-1:0] SAT_MIN = 32'sh8000_0000;

    typedef struct packed {
        logic                     command;
        logic [IDX_W-1:0]         element_index;
        logic signed [DATA_W-1:0] element_value;
        logic signed [DATA_W-1:0] vec_x;
        logic signed [DATA_W-1:0] vec_y;
        logic signed [DATA_W-1:0] vec_z;
        logic signed [DATA_W-1:0] vec_w;
    } t_cmd;

    typedef struct packed {
        logic signed [DATA_W-1:0] out_x;
        logic signed [DATA_W-1:0] out_y;
        logic signed [DATA_W-1:0] out_z;
        logic signed [DATA_W-1:0] out_w;
        logic                     saturated;
    } t_res;

endpackage

// ===== hw/rtl/matrix_vector_transform_4x4_unit.sv =====
// Top level of the 4x4 matrix-vector transform unit.
//
//  Channel   Handshake          Payload
//  command   push / full        i_command, i_element_index, i_element_value, i_vec_x..i_vec_w
//  result    empty / pop        o_out_x, o_out_y, o_out_z, o_out_w, o_saturated
//
// One item per cycle while no transform waits for a result slot: sixteen parallel 32x32 multipliers feed an add tree.
// A transform's result is registered as products, pair sums and row sums; a load yields no result.
// Loads apply in order with transforms, in the execution stage.
// A transform waits in the two-entry command queue while four results are outstanding.
// Synchronous active-low reset empties both queues and restores the identity matrix.
module matrix_vector_transform_4x4_unit
    import mvt_pkg::*;
#(
    parameter int FRAC_BITS = 16
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     push,
    output logic                     full,
    input  logic                     i_command,
    input  logic [IDX_W-1:0]         i_element_index,
    input  logic signed [DATA_W-1:0] i_element_value,
    input  logic signed [DATA_W-1:0] i_vec_x,
    input  logic signed [DATA_W-1:0] i_vec_y,
    input  logic signed [DATA_W-1:0] i_vec_z,
    input  logic signed [DATA_W-1:0] i_vec_w,
    output logic                     empty,
    input  logic                     pop,
    output logic signed [DATA_W-1:0] o_out_x,
    output logic signed [DATA_W-1:0] o_out_y,
    output logic signed [DATA_W-1:0] o_out_z,
    output logic signed [DATA_W-1:0] o_out_w,
    output logic                     o_saturated
);

    t_cmd cmd_in, cmd_head;
    t_res res_back, res_head;
    logic cmd_empty, cmd_ready, res_valid, res_pop;

    assign cmd_in.command       = i_command;
    assign cmd_in.element_index = i_element_index;
    assign cmd_in.element_value = i_element_value;
    assign cmd_in.vec_x         = i_vec_x;
    assign cmd_in.vec_y         = i_vec_y;
    assign cmd_in.vec_z         = i_vec_z;
    assign cmd_in.vec_w         = i_vec_w;

    mvt_fifo #(
        .WIDTH ($bits(t_cmd)),
        .DEPTH (CMD_DEPTH)
    ) u_cmd_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (push),
        .i_wdata (cmd_in),
        .o_full  (full),
        .i_rd    (cmd_ready),
        .o_rdata (cmd_head),
        .o_empty (cmd_empty)
    );

    assign res_pop = pop && !empty;

    mvt_back #(
        .FRAC_BITS (FRAC_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd_head),
        .i_cmd_valid (!cmd_empty),
        .o_cmd_ready (cmd_ready),
        .i_res_pop   (res_pop),
        .o_res       (res_back),
        .o_res_valid (res_valid)
    );

    mvt_fifo #(
        .WIDTH ($bits(t_res)),
        .DEPTH (RES_DEPTH)
    ) u_res_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (res_valid),
        .i_wdata (res_back),
        .o_full  (),
        .i_rd    (pop),
        .o_rdata (res_head),
        .o_empty (empty)
    );

    assign o_out_x     = res_head.out_x;
    assign o_out_y     = res_head.out_y;
    assign o_out_z     = res_head.out_z;
    assign o_out_w     = res_head.out_w;
    assign o_saturated = res_head.saturated;

endmodule

// ===== hw/rtl/mvt_fifo.sv =====
// Small register-based first-in first-out queue used on both sides of the unit.
module mvt_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_wr,
    input  logic [WIDTH-1:0] i_wdata,
    output logic             o_full,
    input  logic             i_rd,
    output logic [WIDTH-1:0] o_rdata,
    output logic             o_empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wptr, n_wptr;
    logic [PTR_W-1:0] r_rptr, n_rptr;
    logic [CNT_W-1:0] r_count, n_count;
    logic             wr_fire, rd_fire;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_empty = (r_count == '0);
    assign wr_fire = i_wr && !o_full;
    assign rd_fire = i_rd && !o_empty;
    assign o_rdata = r_mem[r_rptr];

    always_comb begin
        n_wptr  = r_wptr;
        n_rptr  = r_rptr;
        n_count = r_count;
        if (wr_fire) begin
            n_wptr = (r_wptr == PTR_W'(DEPTH - 1)) ? '0 : r_wptr + 1'b1;
        end
        if (rd_fire) begin
            n_rptr = (r_rptr == PTR_W'(DEPTH - 1)) ? '0 : r_rptr + 1'b1;
        end
        if (wr_fire && !rd_fire) begin
            n_count = r_count + 1'b1;
        end else if (rd_fire && !wr_fire) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_fire) begin
            r_mem[r_wptr] <= i_wdata;
        end
    end

endmodule

// ===== hw/rtl/mvt_back.sv =====
// Execution side: matrix registers, multiply/add pipeline and saturation.
module mvt_back
    import mvt_pkg::*;
#(
    parameter int FRAC_BITS = 16
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  t_cmd i_cmd,
    input  logic i_cmd_valid,
    output logic o_cmd_ready,
    input  logic i_res_pop,
    output t_res o_res,
    output logic o_res_valid
);

    localparam logic signed [DATA_W-1:0] FIX_ONE = DATA_W'(1) << FRAC_BITS;

    logic signed [DATA_W-1:0] r_mat  [N_ELEM];
    logic signed [PROD_W-1:0] r_prod [N_ELEM];
    logic signed [PAIR_W-1:0] r_pair [2*N_DIM];
    logic signed [SUM_W-1:0]  r_sum  [N_DIM];
    logic                     r_v1, r_v2, r_v3;
    logic [RES_CNT_W-1:0]     r_outst, n_outst;

    logic signed [DATA_W-1:0] vec     [N_DIM];
    logic signed [SUM_W-1:0]  shifted [N_DIM];
    logic signed [DATA_W-1:0] clipped [N_DIM];
    logic [N_DIM-1:0]         row_sat;
    logic                     cmd_fire, load_fire, xform_fire;

    assign vec[0] = i_cmd.vec_x;
    assign vec[1] = i_cmd.vec_y;
    assign vec[2] = i_cmd.vec_z;
    assign vec[3] = i_cmd.vec_w;

    // a transform needs a result slot reserved for it, counting those in flight
    assign o_cmd_ready = (i_cmd.command == CMD_LOAD)
                      || (r_outst < RES_CNT_W'(RES_DEPTH)) || i_res_pop;
    assign cmd_fire    = i_cmd_valid && o_cmd_ready;
    assign load_fire   = cmd_fire && (i_cmd.command == CMD_LOAD);
    assign xform_fire  = cmd_fire && (i_cmd.command == CMD_XFORM);

    always_comb begin
        n_outst = r_outst;
        if (xform_fire && !i_res_pop) begin
            n_outst = r_outst + 1'b1;
        end else if (i_res_pop && !xform_fire) begin
            n_outst = r_outst - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1    <= 1'b0;
            r_v2    <= 1'b0;
            r_v3    <= 1'b0;
            r_outst <= '0;
            for (int i = 0; i < N_ELEM; i++) begin
                r_mat[i] <= (i % (N_DIM + 1) == 0) ? FIX_ONE : '0;
            end
        end else begin
            r_v1    <= xform_fire;
            r_v2    <= r_v1;
            r_v3    <= r_v2;
            r_outst <= n_outst;
            if (load_fire) begin
                r_mat[i_cmd.element_index] <= i_cmd.element_value;
            end
        end
    end

    // datapath registers: products, pair sums, row sums
    always_ff @(posedge i_clk) begin
        for (int r = 0; r < N_DIM; r++) begin
            for (int c = 0; c < N_DIM; c++) begin
                r_prod[r*N_DIM+c] <= $signed(r_mat[r*N_DIM+c]) * $signed(vec[c]);
            end
        end
        for (int k = 0; k < 2*N_DIM; k++) begin
            r_pair[k] <= PAIR_W'(r_prod[2*k]) + PAIR_W'(r_prod[2*k+1]);
        end
        for (int r = 0; r < N_DIM; r++) begin
            r_sum[r] <= SUM_W'(r_pair[2*r]) + SUM_W'(r_pair[2*r+1]);
        end
    end

    // floor shift, then clip to 32 bits when the upper bits are not all sign
    always_comb begin
        for (int r = 0; r < N_DIM; r++) begin
            shifted[r] = r_sum[r] >>> FRAC_BITS;
            if ((&shifted[r][SUM_W-1:DATA_W-1]) || !(|shifted[r][SUM_W-1:DATA_W-1])) begin
                row_sat[r] = 1'b0;
                clipped[r] = shifted[r][DATA_W-1:0];
            end else begin
                row_sat[r] = 1'b1;
                clipped[r] = shifted[r][SUM_W-1] ? SAT_MIN : SAT_MAX;
            end
        end
    end

    assign o_res.out_x     = clipped[0];
    assign o_res.out_y     = clipped[1];
    assign o_res.out_z     = clipped[2];
    assign o_res.out_w     = clipped[3];
    assign o_res.saturated = |row_sat;
    assign o_res_valid     = r_v3;

endmodule

// ===== hw/rtl/mvt_checker.sv =====
// Port-level assertions for the transform unit, bound to the top level.
module mvt_checker
    import mvt_pkg::*;
(
    input logic                     i_clk,
    input logic                     i_rst_n,
    input logic                     push,
    input logic                     full,
    input logic                     empty,
    input logic                     pop,
    input logic signed [DATA_W-1:0] o_out_x,
    input logic signed [DATA_W-1:0] o_out_y,
    input logic signed [DATA_W-1:0] o_out_z,
    input logic signed [DATA_W-1:0] o_out_w,
    input logic                     o_saturated
);

    // the result queue comes out of reset empty and the command queue not full
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> empty && !full)
        else $error("queues not empty after reset");

    // the command queue only fills through an accepted transaction
    a_full_needs_push: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(full) |-> $past(push))
        else $error("command queue filled without a push");

    // results only drain through a pop
    a_empty_needs_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(empty) && $past(i_rst_n) |-> $past(pop))
        else $error("result lost without a pop");

    // a waiting result holds until taken
    a_result_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && !pop |=> !empty && $stable(o_out_x) && $stable(o_out_y)
            && $stable(o_out_z) && $stable(o_out_w) && $stable(o_saturated))
        else $error("waiting result changed");

endmodule

bind matrix_vector_transform_4x4_unit mvt_checker u_checker (.*);
